// File: hw/rtl/rcbp_pkg.sv
// ----------------------------------------------------------------------------
// rcbp_pkg - shared types and codes for the ref-counted block pool
// Request/response beat layouts, request and status codes, parameter defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcbp_pkg;

	localparam int NUM_BLOCKS_DEF = 256;
	localparam int COUNT_BITS_DEF = 16;

	localparam int REQ_W   = 3;
	localparam int BIDX_W  = 8;
	localparam int STAT_W  = 2;
	localparam int RCNT_W  = 16;
	localparam int STATS_W = 9;
	localparam int TOTAL_W = 32;

	localparam logic [REQ_W-1:0] REQ_ALLOC   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_RELEASE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_ADDREF  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_QUERY   = 3'd3;
	localparam logic [REQ_W-1:0] REQ_RSTATS  = 3'd4;

	localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STAT_W-1:0] ST_FREE  = 2'd2;
	localparam logic [STAT_W-1:0] ST_SAT   = 2'd3;

	typedef struct packed {
		logic [REQ_W-1:0]  req_type;
		logic [BIDX_W-1:0] block_index;
	} pool_req_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [BIDX_W-1:0]  granted_block;
		logic [RCNT_W-1:0]  ref_count;
		logic [STATS_W-1:0] blocks_in_use;
		logic [STATS_W-1:0] blocks_free;
		logic [STATS_W-1:0] peak_in_use;
		logic [TOTAL_W-1:0] alloc_total;
	} pool_rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/rcbp_ram.sv
// ----------------------------------------------------------------------------
// rcbp_ram - generic single-write, single-read synchronous RAM
// One write port, one read port, read data registered and held between reads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/refcounted_block_pool.sv
// ----------------------------------------------------------------------------
// refcounted_block_pool - fixed block pool with LIFO free stack and refcounts
// Serves alloc, release, add-ref, query and stats-reset requests, one
// response beat per request beat, with pool statistics on every response.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | beat
//  ---------+----------------------+----------------------------------------
//  request  | req_valid/req_ready  | req : pool_req_t (req_type, block_index)
//  response | rsp_valid/rsp_ready  | rsp : pool_rsp_t (status .. alloc_total)
//
//  A request has two steps: a read of the count and stack-top memories, then
//  an update and write back; one request is in flight, so a new request is
//  taken only once the read-modify-write pass through the two RAMs is done.
//  After reset a clearing pass initialises every entry of both RAMs;
//  req_ready is low throughout.
//  A stalled response sits in the output register; one further request may
//  be taken and waits in the update stage until that register frees up.
//
`timescale 1ns / 1ps
`default_nettype none

module refcounted_block_pool #(
	parameter int NUM_BLOCKS = rcbp_pkg::NUM_BLOCKS_DEF,
	parameter int COUNT_BITS = rcbp_pkg::COUNT_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire rcbp_pkg::pool_req_t req,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	output rcbp_pkg::pool_rsp_t     rsp
);

	localparam int IDX_W = $clog2(NUM_BLOCKS);
	localparam int DEP_W = $clog2(NUM_BLOCKS + 1);
	localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

	logic                  clr_q;
	logic [IDX_W-1:0]      clr_idx_q;
	logic                  busy_s1;
	rcbp_pkg::pool_req_t   req_s1;
	logic [DEP_W-1:0]      depth_q, in_use_q, peak_q;
	logic [31:0]           alloc_q;
	rcbp_pkg::pool_rsp_t   rsp_q;
	logic                  rsp_valid_q;

	logic                  accept, done_s1;
	logic [COUNT_BITS-1:0] cnt_rdata;
	logic [IDX_W-1:0]      stk_rdata;

	logic                  cnt_we, stk_we;
	logic [IDX_W-1:0]      cnt_waddr, stk_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	logic [IDX_W-1:0]      stk_wdata;

	logic                  upd_cnt_we, upd_stk_we;
	logic [IDX_W-1:0]      upd_cnt_addr;
	logic [COUNT_BITS-1:0] upd_cnt_data;
	logic                  idx_ok;
	logic [COUNT_BITS-1:0] cur_cnt, count_c;
	logic [1:0]            status_c;
	logic [7:0]            granted_c;
	logic [DEP_W-1:0]      depth_d, in_use_d, peak_d;
	logic [31:0]           alloc_d;

	assign req_ready = !clr_q && !busy_s1;
	assign accept    = req_valid && req_ready;
	assign done_s1   = busy_s1 && (!rsp_valid_q || rsp_ready);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		idx_ok       = 32'(req_s1.block_index) < NUM_BLOCKS;
		cur_cnt      = idx_ok ? cnt_rdata : '0;
		status_c     = rcbp_pkg::ST_OK;
		granted_c    = req_s1.block_index;
		count_c      = '0;
		depth_d      = depth_q;
		in_use_d     = in_use_q;
		peak_d       = peak_q;
		alloc_d      = alloc_q;
		upd_cnt_we   = 1'b0;
		upd_cnt_addr = IDX_W'(req_s1.block_index);
		upd_cnt_data = '0;
		upd_stk_we   = 1'b0;
		case (req_s1.req_type)
			rcbp_pkg::REQ_ALLOC: begin
				if (depth_q == '0) begin
					status_c = rcbp_pkg::ST_EMPTY;
				end else begin
					depth_d      = depth_q - 1'b1;
					upd_cnt_we   = 1'b1;
					upd_cnt_addr = stk_rdata;
					upd_cnt_data = COUNT_BITS'(1);
					count_c      = COUNT_BITS'(1);
					granted_c    = 8'(stk_rdata);
					if (alloc_q != '1) begin
						alloc_d = alloc_q + 1'b1;
					end
					in_use_d = in_use_q + 1'b1;
					if (in_use_d > peak_q) begin
						peak_d = in_use_d;
					end
				end
			end
			rcbp_pkg::REQ_RELEASE: begin
				if (cur_cnt == '0) begin
					status_c = rcbp_pkg::ST_FREE;
				end else if (cur_cnt == COUNT_BITS'(1)) begin
					upd_cnt_we = 1'b1;
					if (32'(depth_q) < NUM_BLOCKS) begin
						upd_stk_we = 1'b1;
						depth_d    = depth_q + 1'b1;
					end
					if (in_use_q != '0) begin
						in_use_d = in_use_q - 1'b1;
					end
				end else begin
					upd_cnt_we   = 1'b1;
					upd_cnt_data = cur_cnt - 1'b1;
					count_c      = cur_cnt - 1'b1;
				end
			end
			rcbp_pkg::REQ_ADDREF: begin
				if (cur_cnt == '0) begin
					status_c = rcbp_pkg::ST_FREE;
				end else if (cur_cnt == CNT_MAX) begin
					status_c = rcbp_pkg::ST_SAT;
					count_c  = cur_cnt;
				end else begin
					upd_cnt_we   = 1'b1;
					upd_cnt_data = cur_cnt + 1'b1;
					count_c      = cur_cnt + 1'b1;
				end
			end
			rcbp_pkg::REQ_QUERY: begin
				count_c = cur_cnt;
			end
			rcbp_pkg::REQ_RSTATS: begin
				alloc_d = '0;
			end
			default: begin
			end
		endcase
	end

	// clearing pass owns the write ports until done
	always_comb begin
		if (clr_q) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_idx_q;
			cnt_wdata = '0;
			stk_we    = 1'b1;
			stk_waddr = clr_idx_q;
			stk_wdata = clr_idx_q;
		end else begin
			cnt_we    = done_s1 && upd_cnt_we;
			cnt_waddr = upd_cnt_addr;
			cnt_wdata = upd_cnt_data;
			stk_we    = done_s1 && upd_stk_we;
			stk_waddr = IDX_W'(depth_q);
			stk_wdata = IDX_W'(req_s1.block_index);
		end
	end

	rcbp_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (NUM_BLOCKS)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (accept),
		.raddr (IDX_W'(req.block_index)),
		.rdata (cnt_rdata)
	);

	rcbp_ram #(
		.WIDTH (IDX_W),
		.DEPTH (NUM_BLOCKS)
	) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (stk_wdata),
		.re    (accept),
		.raddr (IDX_W'(depth_q - 1'b1)),
		.rdata (stk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= 1'b1;
			clr_idx_q   <= '0;
			busy_s1     <= 1'b0;
			rsp_valid_q <= 1'b0;
			depth_q     <= DEP_W'(NUM_BLOCKS);
			in_use_q    <= '0;
			peak_q      <= '0;
			alloc_q     <= '0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (32'(clr_idx_q) == NUM_BLOCKS - 1) begin
					clr_q <= 1'b0;
				end
			end
			if (accept) begin
				busy_s1 <= 1'b1;
			end else if (done_s1) begin
				busy_s1 <= 1'b0;
			end
			if (done_s1) begin
				rsp_valid_q <= 1'b1;
				depth_q     <= depth_d;
				in_use_q    <= in_use_d;
				peak_q      <= peak_d;
				alloc_q     <= alloc_d;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
		if (done_s1) begin
			rsp_q.status        <= status_c;
			rsp_q.granted_block <= granted_c;
			rsp_q.ref_count     <= 16'(count_c);
			rsp_q.blocks_in_use <= 9'(in_use_d);
			rsp_q.blocks_free   <= 9'(depth_d);
			rsp_q.peak_in_use   <= 9'(peak_d);
			rsp_q.alloc_total   <= alloc_d;
		end
	end

	a_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		!clr_q |-> (32'(in_use_q) + 32'(depth_q) == NUM_BLOCKS))
		else $error("in-use plus free count differs from pool size");

	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		peak_q >= in_use_q)
		else $error("peak below current in-use count");

	a_done_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		done_s1 |=> rsp_valid)
		else $error("completed request produced no response beat");

	a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && (cnt_we || stk_we)))
		else $error("memory write overlaps a request read");

endmodule

`default_nettype wire
